[rtl/qltu_pkg.sv]
// ----------------------------------------------------------------------------
// qltu_pkg
// Shared types, constants and helpers for the Q-table update core.
// ----------------------------------------------------------------------------
package qltu_pkg;

    // Grid geometry defaults
    localparam int unsigned GRID_ROWS_DEF = 16;
    localparam int unsigned GRID_COLS_DEF = 16;
    localparam int unsigned NUM_ACTIONS   = 4;
    localparam int unsigned ACT_W         = 2;
    localparam int unsigned COORD_W       = 4;
    localparam int unsigned VAL_W         = 32;
    localparam int unsigned RATE_W        = 16;

    // Intermediate widths of the update arithmetic
    localparam int unsigned GPROD_W = RATE_W + 1 + VAL_W;   // gamma * maxQ
    localparam int unsigned G_W     = GPROD_W - 16;         // floor(gamma*maxQ / 2^16)
    localparam int unsigned D_W     = VAL_W + 2;            // reward + g - q
    localparam int unsigned APROD_W = RATE_W + 1 + D_W;     // alpha * d
    localparam int unsigned DELTA_W = APROD_W - 16;         // floor(alpha*d / 2^16)
    localparam int unsigned NV_W    = DELTA_W + 1;          // q + delta

    // Stream packing
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 72;

    // Configuration register map
    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0]  REG_LEARN_RATE = 1'b0;
    localparam logic [0:0]  REG_DISCOUNT   = 1'b1;
    localparam logic [RATE_W-1:0] LEARN_RATE_RST = 16'd6554;
    localparam logic [RATE_W-1:0] DISCOUNT_RST   = 16'd58982;

    // Item opcodes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef logic signed [VAL_W-1:0] qval_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAX,
        ST_GMUL,
        ST_DIFF,
        ST_AMUL,
        ST_DONE
    } state_t;

    // Load strobes from the sequencer to the arithmetic stages
    typedef struct packed {
        logic ld_best;
        logic ld_gq;
        logic ld_diff;
        logic ld_prod;
    } arith_ctrl_t;

    // Pin a coordinate beyond the grid to the last row or column
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                       input int unsigned lim);
        logic [COORD_W-1:0] res;
        if (int'(v) >= int'(lim)) begin
            res = COORD_W'(lim - 1);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

[rtl/qltu_table.sv]
// ----------------------------------------------------------------------------
// qltu_table
// Q table storage: one synchronous memory with one cell of four action
// values per entry, a per-action lane write and a registered whole-cell read.
// ----------------------------------------------------------------------------
module qltu_table
    import qltu_pkg::*;
#(
    parameter int unsigned CELLS  = GRID_ROWS_DEF * GRID_COLS_DEF,
    parameter int unsigned CELL_W = 8
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic                wr_all,
    input  logic [ACT_W-1:0]    wr_bank,
    input  logic [CELL_W-1:0]   wr_addr,
    input  qval_t               wr_data,
    input  logic                rd_en,
    input  logic [CELL_W-1:0]   rd_addr,
    output qval_t               rd_data [NUM_ACTIONS]
);

    typedef logic [NUM_ACTIONS-1:0][VAL_W-1:0] cell_word_t;

    cell_word_t mem [CELLS];
    cell_word_t rd_data_reg;

    // Write the addressed action lane, or the whole cell during the clearing pass
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            if (wr_all) begin
                mem[wr_addr] <= {NUM_ACTIONS{wr_data}};
            end else begin
                mem[wr_addr][wr_bank] <= wr_data;
            end
        end
    end

    // Read the whole cell
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    for (genvar b = 0; b < NUM_ACTIONS; b++) begin : g_lane
        assign rd_data[b] = rd_data_reg[b];
    end

endmodule

[rtl/qltu_arith.sv]
// ----------------------------------------------------------------------------
// qltu_arith
// Arithmetic stages: first-maximum search over one cell, gamma multiply,
// temporal difference, alpha multiply and saturating accumulate.
// ----------------------------------------------------------------------------
module qltu_arith
    import qltu_pkg::*;
(
    input  logic                aclk,
    input  arith_ctrl_t         ctrl,
    input  qval_t               rd_data [NUM_ACTIONS],
    input  logic [ACT_W-1:0]    act,
    input  qval_t               reward,
    input  logic [RATE_W-1:0]   learn_rate,
    input  logic [RATE_W-1:0]   discount,
    output logic [ACT_W-1:0]    best_action,
    output qval_t               best_value,
    output qval_t               new_value,
    output logic                saturated
);

    logic [ACT_W-1:0]         ba_reg, ba_next;
    qval_t                    bv_reg, bv_next;
    qval_t                    q_reg;
    logic signed [G_W-1:0]    g_reg;
    logic signed [D_W-1:0]    d_reg, d_next;
    logic signed [DELTA_W-1:0] delta_reg;
    logic signed [GPROD_W-1:0] g_prod;
    logic signed [APROD_W-1:0] a_prod;
    logic signed [NV_W-1:0]   nv;

    // First maximum wins: only a strictly larger value replaces the best
    always_comb begin
        ba_next = '0;
        bv_next = rd_data[0];
        for (int i = 1; i < NUM_ACTIONS; i++) begin
            if (rd_data[i] > bv_next) begin
                bv_next = rd_data[i];
                ba_next = ACT_W'(i);
            end
        end
    end

    assign g_prod = $signed({1'b0, discount}) * bv_reg;
    assign d_next = $signed({{(D_W-VAL_W){reward[VAL_W-1]}}, reward})
                  + $signed({{(D_W-G_W){g_reg[G_W-1]}}, g_reg})
                  - $signed({{(D_W-VAL_W){q_reg[VAL_W-1]}}, q_reg});
    assign a_prod = $signed({1'b0, learn_rate}) * d_reg;

    // Stage registers, loaded one step at a time by the sequencer
    always_ff @(posedge aclk) begin
        if (ctrl.ld_best) begin
            ba_reg <= ba_next;
            bv_reg <= bv_next;
        end
        if (ctrl.ld_gq) begin
            g_reg <= g_prod[GPROD_W-1:16];
            q_reg <= rd_data[act];
        end
        if (ctrl.ld_diff) begin
            d_reg <= d_next;
        end
        if (ctrl.ld_prod) begin
            delta_reg <= a_prod[APROD_W-1:16];
        end
    end

    // Accumulate and clip to the 32-bit range
    assign nv = $signed({{(NV_W-VAL_W){q_reg[VAL_W-1]}}, q_reg})
              + $signed({delta_reg[DELTA_W-1], delta_reg});

    always_comb begin
        saturated = 1'b0;
        new_value = nv[VAL_W-1:0];
        if (nv[NV_W-1:VAL_W-1] != {(NV_W-VAL_W+1){nv[NV_W-1]}}) begin
            saturated = 1'b1;
            new_value = nv[NV_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    assign best_action = ba_reg;
    assign best_value  = bv_reg;

endmodule

[rtl/q_learning_table_update_core.sv]
// ----------------------------------------------------------------------------
// q_learning_table_update_core
// Tabular Q-learning update engine with a grid-indexed table of four
// signed Q16.16 action values per cell.
// ----------------------------------------------------------------------------
// After reset the core clears the table, one cell per cycle, through all
// GRID_ROWS*GRID_COLS cells; s_tready stays low meanwhile while the APB port
// is served as usual. One word is worked on at a time. An update word goes
// through one read of the next cell's four values, one read of the current
// entry, the gamma multiply, the difference, the alpha multiply and the
// write-back, all sequenced around the single read port of the table. A select
// word reads and searches its own cell and writes nothing back. The result sits
// in an output register, so the next word is taken while a result waits on
// m_tready; a second result waits in the write-back step until the first is taken.
// ----------------------------------------------------------------------------
module q_learning_table_update_core
    import qltu_pkg::*;
#(
    parameter int unsigned GRID_ROWS = GRID_ROWS_DEF,
    parameter int unsigned GRID_COLS = GRID_COLS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] cur_row, [7:4] cur_col, [9:8] action_in, [13:10] next_row,
    // [17:14] next_col, [49:18] reward, [55:50] zero
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // [0] opcode
    input  logic                   s_tuser,
    // Result words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] best_action, [33:2] best_value, [65:34] new_value,
    // [66] saturated, [71:67] zero
    output logic [M_TDATA_W-1:0]   m_tdata,
    // Configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int unsigned CELLS  = GRID_ROWS * GRID_COLS;
    localparam int unsigned CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    state_t                  state_reg, state_next;
    logic [CELL_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                    op_reg;
    logic [CELL_W-1:0]       cur_cell_reg;
    logic [ACT_W-1:0]        act_reg;
    qval_t                   reward_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]    m_data_reg, m_data_next;
    logic [RATE_W-1:0]       learn_rate_reg, discount_reg;

    logic                    accept, out_free, cfg_wr;
    logic [CELL_W-1:0]       cur_cell_in, nxt_cell_in;
    logic                    tbl_wr_en, tbl_wr_all, tbl_rd_en;
    logic [CELL_W-1:0]       tbl_wr_addr, tbl_rd_addr;
    qval_t                   tbl_wr_data;
    qval_t                   rd_data [NUM_ACTIONS];
    arith_ctrl_t             ctrl;
    logic [ACT_W-1:0]        best_action;
    qval_t                   best_value, new_value;
    logic                    saturated;
    logic                    load_out;

    // Cell index of a clamped coordinate pair
    function automatic logic [CELL_W-1:0] cell_of(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        r = clamp_coord(row, GRID_ROWS);
        c = clamp_coord(col, GRID_COLS);
        return CELL_W'(int'(r) * GRID_COLS + int'(c));
    endfunction

    assign cur_cell_in = cell_of(s_tdata[3:0], s_tdata[7:4]);
    assign nxt_cell_in = cell_of(s_tdata[13:10], s_tdata[17:14]);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_rate_reg <= LEARN_RATE_RST;
            discount_reg   <= DISCOUNT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LEARN_RATE: learn_rate_reg <= pwdata[RATE_W-1:0];
                REG_DISCOUNT:   discount_reg   <= pwdata[RATE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LEARN_RATE: prdata = {16'd0, learn_rate_reg};
            REG_DISCOUNT:   prdata = {16'd0, discount_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CELL_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MAX;
                end
            end
            ST_MAX:  state_next = (op_reg == OP_SELECT) ? ST_DONE : ST_GMUL;
            ST_GMUL: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_AMUL;
            ST_AMUL: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        tbl_wr_en    = 1'b0;
        tbl_wr_all   = 1'b0;
        tbl_wr_addr  = cur_cell_reg;
        tbl_wr_data  = new_value;
        tbl_rd_en    = 1'b0;
        tbl_rd_addr  = cur_cell_reg;
        ctrl         = '0;
        load_out     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                tbl_wr_en   = 1'b1;
                tbl_wr_all  = 1'b1;
                tbl_wr_addr = clr_cnt_reg;
                tbl_wr_data = '0;
            end
            ST_IDLE: begin
                // Fetch the cell to search: next cell for update, own cell for select
                tbl_rd_en   = accept;
                tbl_rd_addr = (s_tuser == OP_SELECT) ? cur_cell_in : nxt_cell_in;
            end
            ST_MAX: begin
                ctrl.ld_best = 1'b1;
                tbl_rd_en    = (op_reg == OP_UPDATE);
            end
            ST_GMUL: ctrl.ld_gq   = 1'b1;
            ST_DIFF: ctrl.ld_diff = 1'b1;
            ST_AMUL: ctrl.ld_prod = 1'b1;
            ST_DONE: begin
                load_out  = out_free;
                tbl_wr_en = out_free && (op_reg == OP_UPDATE);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
            if (op_reg == OP_SELECT) begin
                m_data_next = {5'd0, 1'b0, 32'd0, best_value, best_action};
            end else begin
                m_data_next = {5'd0, saturated, new_value, best_value, best_action};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the item fields and the result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            op_reg       <= s_tuser;
            cur_cell_reg <= cur_cell_in;
            act_reg      <= s_tdata[9:8];
            reward_reg   <= s_tdata[49:18];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Table and arithmetic
    // ------------------------------------------------------------------
    qltu_table #(
        .CELLS  (CELLS),
        .CELL_W (CELL_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_all  (tbl_wr_all),
        .wr_bank (act_reg),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (rd_data)
    );

    qltu_arith u_arith (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .rd_data     (rd_data),
        .act         (act_reg),
        .reward      (reward_reg),
        .learn_rate  (learn_rate_reg),
        .discount    (discount_reg),
        .best_action (best_action),
        .best_value  (best_value),
        .new_value   (new_value),
        .saturated   (saturated)
    );

`ifndef SYNTHESIS
    // Table writes happen only in the clearing pass or at write-back
    a_wr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr_en |-> (state_reg == ST_CLEAR) || (state_reg == ST_DONE))
        else $error("table write outside clear or write-back");

    // A select word never modifies the table
    a_select_no_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        (tbl_wr_en && (state_reg == ST_DONE)) |-> (op_reg == OP_UPDATE))
        else $error("table written by a select word");

    // An accepted word starts the search in the next cycle
    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_MAX))
        else $error("accepted word did not start the search");

    // A new result comes only from the write-back step
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> ($past(state_reg) == ST_DONE))
        else $error("result appeared outside write-back");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q-table update core. Update and select words
// are streamed in under random source gaps and sink stalls. The bench keeps
// its own copy of the table and the two rates, predicts every result word,
// and checks each result field by field in arrival order. The learning rate
// and discount are moved through several settings between drained phases,
// including both extremes.
// ----------------------------------------------------------------------------
module tb
    import qltu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned GRID_ROWS = 16;
    localparam int unsigned GRID_COLS = 16;
    localparam int unsigned TABLE_DEPTH = GRID_ROWS * GRID_COLS * NUM_ACTIONS;
    localparam int unsigned RANDOM_WORDS = 233;    // per rate setting
    localparam longint RUN_LIMIT = 5_000_000;      // ns

    localparam logic [PADDR_W-1:0] ADDR_LEARN_RATE = {REG_LEARN_RATE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_DISCOUNT   = {REG_DISCOUNT, 2'b00};

    // Grid moves used to build walks, indexed by the action taken
    localparam logic [ACT_W-1:0] MOVE_UP    = 2'd0;
    localparam logic [ACT_W-1:0] MOVE_DOWN  = 2'd1;
    localparam logic [ACT_W-1:0] MOVE_LEFT  = 2'd2;
    localparam logic [ACT_W-1:0] MOVE_RIGHT = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                      opcode;
        logic signed [VAL_W-1:0]   reward;
        logic [COORD_W-1:0]        next_col;
        logic [COORD_W-1:0]        next_row;
        logic [ACT_W-1:0]          action;
        logic [COORD_W-1:0]        cur_col;
        logic [COORD_W-1:0]        cur_row;
    } step_t;

    localparam int unsigned STEP_W = $bits(step_t);

    // Same bit order as m_tdata[66:0]
    typedef struct packed {
        logic                      saturated;
        logic signed [VAL_W-1:0]   new_value;
        logic signed [VAL_W-1:0]   best_value;
        logic [ACT_W-1:0]          best_action;
    } q_result_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [3:0] cur_row, [7:4] cur_col, [9:8] action_in, [13:10] next_row,
    // [17:14] next_col, [49:18] reward, [55:50] zero
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    // [0] opcode
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [1:0] best_action, [33:2] best_value, [65:34] new_value,
    // [66] saturated, [71:67] zero
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Shadow state of the core
    logic signed [VAL_W-1:0] q_shadow [TABLE_DEPTH];
    logic [RATE_W-1:0]       alpha_cfg;
    logic [RATE_W-1:0]       gamma_cfg;

    step_t       pending_steps [$];
    q_result_t   awaited_results [$];
    step_t       drv_step;

    int unsigned tx_gap, tx_calm, rx_stall, rx_calm;
    int unsigned fail_count, n_updates, n_selects, n_results, n_saturated;

    q_learning_table_update_core #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Gap length: mostly none or short, a few long, with calm stretches
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned roll;
        roll = $urandom_range(0, 999);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if (roll < 8) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 550) return 0;
        if (roll < 900) return $urandom_range(1, 3);
        if (roll < 980) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pin out-of-grid coordinates to the last row or column
    function automatic int unsigned cell_base(input logic [COORD_W-1:0] row,
                                              input logic [COORD_W-1:0] col);
        int unsigned r, c;
        r = (row >= GRID_ROWS) ? GRID_ROWS - 1 : row;
        c = (col >= GRID_COLS) ? GRID_COLS - 1 : col;
        return (r * GRID_COLS + c) * NUM_ACTIONS;
    endfunction

    // Greedy action of one cell; the lowest index wins ties
    function automatic logic [ACT_W-1:0] greedy_of(input int unsigned base,
                                                   output logic signed [VAL_W-1:0] top);
        logic [ACT_W-1:0] top_act;
        int unsigned i;
        top_act = '0;
        top = q_shadow[base];
        for (i = 1; i < NUM_ACTIONS; i++) begin
            if (q_shadow[base + i] > top) begin
                top = q_shadow[base + i];
                top_act = ACT_W'(i);
            end
        end
        return top_act;
    endfunction

    // Work out the result of one word and apply it to the shadow table
    function automatic q_result_t q_update_predict(input step_t st);
        q_result_t res;
        logic signed [VAL_W-1:0] top;
        int unsigned cur, nxt;
        longint q, g, d, delta, nv;
        res = '0;
        cur = cell_base(st.cur_row, st.cur_col);
        if (st.opcode == OP_SELECT) begin
            res.best_action = greedy_of(cur, top);
            res.best_value = top;
            return res;
        end
        nxt = cell_base(st.next_row, st.next_col);
        // next-cell max is taken before the write-back
        res.best_action = greedy_of(nxt, top);
        res.best_value = top;
        q = longint'(q_shadow[cur + st.action]);
        g = (longint'(gamma_cfg) * longint'(top)) >>> 16;
        d = longint'(st.reward) + g - q;
        delta = (longint'(alpha_cfg) * d) >>> 16;
        nv = q + delta;
        if (nv > longint'(VAL_MAX)) begin
            nv = longint'(VAL_MAX);
            res.saturated = 1'b1;
        end else if (nv < longint'(VAL_MIN)) begin
            nv = longint'(VAL_MIN);
            res.saturated = 1'b1;
        end
        q_shadow[cur + st.action] = nv[VAL_W-1:0];
        res.new_value = nv[VAL_W-1:0];
        return res;
    endfunction

    // Source side: present queued words, predict each one as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                awaited_results.push_back(q_update_predict(drv_step));
                if (drv_step.opcode == OP_SELECT) n_selects++;
                else n_updates++;
            end
            if (tx_gap != 0 || pending_steps.size() == 0) begin
                s_tvalid <= 1'b0;
                if (tx_gap != 0) tx_gap <= tx_gap - 1;
            end else begin
                drv_step = pending_steps.pop_front();
                s_tdata <= {{(S_TDATA_W - 50){1'b0}}, drv_step.reward, drv_step.next_col,
                            drv_step.next_row, drv_step.action, drv_step.cur_col,
                            drv_step.cur_row};
                s_tuser <= drv_step.opcode;
                s_tvalid <= 1'b1;
                tx_gap <= pick_gap(tx_calm);
            end
        end
    end

    // Sink side: stall at random, check every result word taken
    always @(posedge aclk) begin
        q_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[66:0];
                n_results++;
                if (got.saturated) n_saturated++;
                if (awaited_results.size() == 0) begin
                    $display("%0t MISMATCH unexpected result word: expected none, actual %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.best_action !== want.best_action) begin
                        $display("%0t MISMATCH best_action: expected %0d, actual %0d",
                                 $time, want.best_action, got.best_action);
                        fail_count++;
                    end
                    if (got.best_value !== want.best_value) begin
                        $display("%0t MISMATCH best_value: expected %0d, actual %0d",
                                 $time, want.best_value, got.best_value);
                        fail_count++;
                    end
                    if (got.new_value !== want.new_value) begin
                        $display("%0t MISMATCH new_value: expected %0d, actual %0d",
                                 $time, want.new_value, got.new_value);
                        fail_count++;
                    end
                    if (got.saturated !== want.saturated) begin
                        $display("%0t MISMATCH saturated: expected %0d, actual %0d",
                                 $time, want.saturated, got.saturated);
                        fail_count++;
                    end
                end
            end
            if (rx_stall != 0) begin
                m_tready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                m_tready <= 1'b1;
                rx_stall <= pick_gap(rx_calm);
            end
        end
    end

    // Hold until every queued word is taken and every result has arrived
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_steps.size() != 0 || s_tvalid || awaited_results.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [RATE_W-1:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_LEARN_RATE) alpha_cfg = val;
        else gamma_cfg = val;
    endtask

    task automatic reg_read_check(input logic [PADDR_W-1:0] addr, input logic [RATE_W-1:0] want);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {16'd0, want}) begin
            $display("%0t MISMATCH register read at %0d: expected %0d, actual %0d",
                     $time, addr, want, prdata);
            fail_count++;
        end
        if (pready !== 1'b1) begin
            $display("%0t MISMATCH pready: expected 1, actual %b", $time, pready);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_rates(input logic [RATE_W-1:0] alpha, input logic [RATE_W-1:0] gamma);
        reg_write(ADDR_LEARN_RATE, alpha);
        reg_write(ADDR_DISCOUNT, gamma);
        reg_read_check(ADDR_LEARN_RATE, alpha);
        reg_read_check(ADDR_DISCOUNT, gamma);
    endtask

    task automatic push_step(input logic op, input int cr, input int cc, input int act,
                             input int nr, input int nc, input logic signed [VAL_W-1:0] rew);
        step_t st;
        st.opcode = op;
        st.cur_row = COORD_W'(cr);
        st.cur_col = COORD_W'(cc);
        st.action = ACT_W'(act);
        st.next_row = COORD_W'(nr);
        st.next_col = COORD_W'(nc);
        st.reward = rew;
        pending_steps.push_back(st);
    endtask

    function automatic logic signed [VAL_W-1:0] rand_reward();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return VAL_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
        if (roll < 75) return $urandom;
        if (roll < 85) begin
            case ($urandom_range(0, 3))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        return VAL_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    endfunction

    // Fully random word, either kind
    task automatic push_noise(inout int unsigned budget);
        step_t st;
        st = STEP_W'({$urandom, $urandom});
        st.reward = rand_reward();
        pending_steps.push_back(st);
        budget--;
    endtask

    // Walk through the grid: updates along a path, a few greedy lookups
    task automatic push_walk(inout int unsigned budget);
        step_t st;
        int unsigned len, k;
        logic [COORD_W-1:0] r, c;
        len = $urandom_range(3, 12);
        if ($urandom_range(0, 3) != 0) begin
            r = COORD_W'($urandom_range(0, 5));
            c = COORD_W'($urandom_range(0, 5));
        end else begin
            r = COORD_W'($urandom);
            c = COORD_W'($urandom);
        end
        for (k = 0; k < len && budget != 0; k++) begin
            st = STEP_W'({$urandom, $urandom});
            st.cur_row = r;
            st.cur_col = c;
            if ($urandom_range(0, 4) == 0) begin
                st.opcode = OP_SELECT;
            end else begin
                st.opcode = OP_UPDATE;
                case (st.action)
                    MOVE_UP:    r = (r == 0) ? r : r - 1'b1;
                    MOVE_DOWN:  r = (r == COORD_W'(GRID_ROWS - 1)) ? r : r + 1'b1;
                    MOVE_LEFT:  c = (c == 0) ? c : c - 1'b1;
                    MOVE_RIGHT: c = (c == COORD_W'(GRID_COLS - 1)) ? c : c + 1'b1;
                    default: ;
                endcase
                st.next_row = r;
                st.next_col = c;
                st.reward = rand_reward();
            end
            pending_steps.push_back(st);
            budget--;
        end
        if (budget != 0) begin
            push_step(OP_SELECT, int'(r), int'(c), int'($urandom_range(0, 3)),
                      int'($urandom_range(0, 15)), int'($urandom_range(0, 15)), $urandom);
            budget--;
        end
    endtask

    // Run limit
    initial begin
        #(RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [RATE_W-1:0] rate_a [7];
        logic [RATE_W-1:0] rate_g [7];
        int unsigned budget, p, i;

        for (i = 0; i < TABLE_DEPTH; i++) q_shadow[i] = '0;
        alpha_cfg = LEARN_RATE_RST;
        gamma_cfg = DISCOUNT_RST;
        fail_count = 0;
        n_updates = 0;
        n_selects = 0;
        n_results = 0;
        n_saturated = 0;
        tx_calm = 0;
        rx_calm = 0;

        rate_a = '{16'd0, 16'd65535, 16'd0, 16'd32768, 16'd0, LEARN_RATE_RST, 16'd65535};
        rate_g = '{16'd0, 16'd0, 16'd65535, 16'd49152, 16'd0, DISCOUNT_RST, 16'd65535};
        rate_a[4] = RATE_W'($urandom_range(0, 65535));
        rate_g[4] = RATE_W'($urandom_range(0, 65535));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset rates: empty table ties, corners, same-cell update
        reg_read_check(ADDR_LEARN_RATE, LEARN_RATE_RST);
        reg_read_check(ADDR_DISCOUNT, DISCOUNT_RST);
        push_step(OP_SELECT, 0, 0, 0, 0, 0, '0);
        push_step(OP_SELECT, 15, 15, 3, 15, 15, '1);
        push_step(OP_UPDATE, 0, 0, 3, 15, 15, VAL_MAX);
        push_step(OP_UPDATE, 15, 15, 0, 0, 0, VAL_MIN);
        push_step(OP_UPDATE, 0, 0, 1, 0, 0, VAL_MAX);
        push_step(OP_SELECT, 0, 0, 0, 0, 0, '0);
        push_step(OP_UPDATE, 15, 15, 2, 15, 15, '1);
        push_step(OP_SELECT, 15, 15, 0, 0, 0, '0);
        push_step(OP_UPDATE, 7, 8, 1, 8, 7, '0);
        wait_drained();

        // Full rates: drive one entry past the top, one cell past the bottom
        set_rates(16'd65535, 16'd65535);
        push_step(OP_UPDATE, 5, 10, 2, 5, 10, VAL_MAX);
        push_step(OP_UPDATE, 5, 10, 2, 5, 10, VAL_MAX);
        push_step(OP_SELECT, 5, 10, 0, 0, 0, '0);
        for (i = 0; i < NUM_ACTIONS; i++) push_step(OP_UPDATE, 10, 5, i, 10, 5, VAL_MIN);
        push_step(OP_UPDATE, 10, 5, 0, 10, 5, VAL_MIN);
        push_step(OP_SELECT, 10, 5, 0, 0, 0, '0);
        push_step(OP_UPDATE, 3, 12, 1, 10, 5, '0);
        push_step(OP_SELECT, 3, 12, 0, 0, 0, '0);
        wait_drained();

        // Random phases, one per rate setting
        for (p = 0; p < 7; p++) begin
            set_rates(rate_a[p], rate_g[p]);
            budget = RANDOM_WORDS;
            while (budget != 0) begin
                if ($urandom_range(0, 4) == 0) push_noise(budget);
                else push_walk(budget);
            end
            wait_drained();
        end

        repeat (16) @(posedge aclk);
        $display("covered %0d updates and %0d selects over 9 rate settings", n_updates, n_selects);
        $display("checked %0d result words, %0d of them saturated", n_results, n_saturated);
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[q_learning_table_update_core.f]
rtl/qltu_pkg.sv
rtl/qltu_table.sv
rtl/qltu_arith.sv
rtl/q_learning_table_update_core.sv
tb/tb.sv
